// ===== sv/hmng_pkg.sv =====
// ----------------------------------------------------------------------------
// hmng_pkg
// Shared types and constants of the heightmap normal generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hmng_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int ROW_LIMIT   = 1024;
  localparam int HEIGHT_BITS = 16;
  localparam int NORMAL_BITS = 16;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int POS_W       = 10;
  localparam int DIM_W       = 11;
  localparam int STEP_W      = 16;
  localparam int DIFF_W      = HEIGHT_BITS + 1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_STEP = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One normal to compute: height differences of both triangles and position
  typedef struct packed {
    logic signed [DIFF_W-1:0] drow;
    logic signed [DIFF_W-1:0] dcol;
    logic [STEP_W-1:0]        step;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     frame_end;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_RD1,
    FR_RD2,
    FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ABS,
    BK_SHIFT,
    BK_SQ,
    BK_SQRT,
    BK_DINIT,
    BK_DIV,
    BK_NEXT,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ===== sv/hmng_front.sv =====
// ----------------------------------------------------------------------------
// hmng_front
// Accepts height samples, keeps the previous row in a line store and turns
// each sample into zero, one or two normal jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hmng_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [hmng_pkg::DIM_W-1:0]           rows_i,
  input  wire logic [hmng_pkg::DIM_W-1:0]           cols_i,
  input  wire logic [hmng_pkg::STEP_W-1:0]          step_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [hmng_pkg::HEIGHT_BITS-1:0] height_i,
  output logic                                      job_valid_o,
  input  wire logic                                 job_ready_i,
  output hmng_pkg::job_t                            job_o
);
  import hmng_pkg::*;

  front_state_e state_q, state_d;

  logic [POS_W-1:0] pos_r_q, pos_r_d, pos_c_q, pos_c_d;
  logic [POS_W-1:0] cur_r_q, cur_r_d, cur_c_q, cur_c_d;
  logic signed [HEIGHT_BITS-1:0] h_q, h_d, up_q, up_d, prior_q, prior_d;
  logic [2:0] pend_q, pend_d;
  job_t       jobs_q [3];
  job_t       jobs_d [3];

  logic signed [HEIGHT_BITS-1:0] mem [MAX_COLS];
  logic signed [HEIGHT_BITS-1:0] rd_data_q;
  logic [COL_W-1:0]              rd_addr;
  logic                          rd_en, wr_en;

  logic             restart;
  logic [POS_W-1:0] eff_r, eff_c;
  logic [DIM_W-1:0] c_plus, r_plus;
  logic [POS_W-1:0] nc;
  logic             last_row, big;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[cur_c_q] <= h_q;
    end
  end

  always_comb begin
    restart = ({1'b0, pos_r_q} >= rows_i) || ({1'b0, pos_c_q} >= cols_i);
    eff_r   = restart ? '0 : pos_r_q;
    eff_c   = restart ? '0 : pos_c_q;
    c_plus  = {1'b0, cur_c_q} + DIM_W'(1);
    r_plus  = {1'b0, cur_r_q} + DIM_W'(1);
    nc      = (c_plus < cols_i) ? c_plus[POS_W-1:0] : cur_c_q;
    last_row = ({1'b0, cur_r_q} == rows_i - DIM_W'(1));
    big      = (rows_i >= DIM_W'(2)) && (cols_i >= DIM_W'(2));
  end

  always_comb begin
    state_d = state_q;
    pos_r_d = pos_r_q;
    pos_c_d = pos_c_q;
    cur_r_d = cur_r_q;
    cur_c_d = cur_c_q;
    h_d     = h_q;
    up_d    = up_q;
    prior_d = prior_q;
    pend_d  = pend_q;
    jobs_d  = jobs_q;
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    job_o       = jobs_q[0];
    rd_en   = 1'b0;
    rd_addr = eff_c;
    wr_en   = 1'b0;

    unique case (state_q)
      FR_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          h_d     = height_i;
          cur_r_d = eff_r;
          cur_c_d = eff_c;
          rd_en   = 1'b1;
          state_d = FR_RD1;
        end
      end
      FR_RD1: begin
        up_d    = rd_data_q;
        rd_addr = nc;
        rd_en   = 1'b1;
        state_d = FR_RD2;
      end
      FR_RD2: begin
        // Row triangle job for the point above
        jobs_d[0].drow      = DIFF_W'(h_q) - DIFF_W'(up_q);
        jobs_d[0].dcol      = DIFF_W'(rd_data_q) - DIFF_W'(up_q);
        jobs_d[0].step      = step_i;
        jobs_d[0].row       = cur_r_q - POS_W'(1);
        jobs_d[0].col       = cur_c_q;
        jobs_d[0].frame_end = 1'b0;
        // Last row: the point to the left
        jobs_d[1].drow      = '0;
        jobs_d[1].dcol      = DIFF_W'(h_q) - DIFF_W'(prior_q);
        jobs_d[1].step      = step_i;
        jobs_d[1].row       = cur_r_q;
        jobs_d[1].col       = cur_c_q - POS_W'(1);
        jobs_d[1].frame_end = 1'b0;
        // Corner point, flat by construction
        jobs_d[2].drow      = '0;
        jobs_d[2].dcol      = '0;
        jobs_d[2].step      = step_i;
        jobs_d[2].row       = POS_W'(rows_i - DIM_W'(1));
        jobs_d[2].col       = POS_W'(cols_i - DIM_W'(1));
        jobs_d[2].frame_end = 1'b1;
        pend_d[0] = (cur_r_q != '0);
        pend_d[1] = last_row && (cols_i >= DIM_W'(2)) && (cur_c_q != '0);
        pend_d[2] = last_row && ((big && (cur_c_q == '0)) ||
                    (!big && ({1'b0, cur_c_q} == cols_i - DIM_W'(1))));
        wr_en   = 1'b1;
        prior_d = h_q;
        if (c_plus >= cols_i) begin
          pos_c_d = '0;
          pos_r_d = (r_plus >= rows_i) ? '0 : r_plus[POS_W-1:0];
        end else begin
          pos_c_d = c_plus[POS_W-1:0];
          pos_r_d = cur_r_q;
        end
        state_d = FR_PUSH;
      end
      FR_PUSH: begin
        job_valid_o = (pend_q != '0);
        if (pend_q[0]) begin
          job_o = jobs_q[0];
          if (job_ready_i) begin
            pend_d[0] = 1'b0;
          end
        end else if (pend_q[1]) begin
          job_o = jobs_q[1];
          if (job_ready_i) begin
            pend_d[1] = 1'b0;
          end
        end else begin
          job_o = jobs_q[2];
          if (job_ready_i) begin
            pend_d[2] = 1'b0;
          end
        end
        if ((pend_q == '0) || (job_ready_i && ($countones(pend_q) == 1))) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      pos_r_q <= '0;
      pos_c_q <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_r_q <= pos_r_d;
      pos_c_q <= pos_c_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    h_q     <= h_d;
    up_q    <= up_d;
    prior_q <= prior_d;
    jobs_q  <= jobs_d;
  end

endmodule

`default_nettype wire

// ===== sv/hmng_queue.sv =====
// ----------------------------------------------------------------------------
// hmng_queue
// Short job queue between the front end and the normalization back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hmng_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_valid_i,
  output logic         push_ready_o,
  input  wire hmng_pkg::job_t push_job_i,
  output logic         pop_valid_o,
  input  wire logic    pop_ready_i,
  output hmng_pkg::job_t pop_job_o
);
  import hmng_pkg::*;

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = slots_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - QCNT_W'(1)))
    else $error("queue count did not shrink on pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree while empty");

endmodule

`default_nettype wire

// ===== sv/hmng_back.sv =====
// ----------------------------------------------------------------------------
// hmng_back
// Shared normalization unit: normalizes both triangle normals and their sum
// with a bit-serial square root and divider, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hmng_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  output logic          job_ready_o,
  input  wire hmng_pkg::job_t job_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic signed [hmng_pkg::NORMAL_BITS-1:0] normal_x_o,
  output logic signed [hmng_pkg::NORMAL_BITS-1:0] normal_y_o,
  output logic signed [hmng_pkg::NORMAL_BITS-1:0] normal_z_o,
  output logic [hmng_pkg::POS_W-1:0]              out_row_o,
  output logic [hmng_pkg::POS_W-1:0]              out_col_o,
  output logic                                     frame_end_o
);
  import hmng_pkg::*;

  localparam int VEC_W = 34;
  localparam int MAG_W = 33;
  localparam int RES_W = 32;
  localparam int FRAC_TRI = 30;
  localparam int FRAC_OUT = NORMAL_BITS - 2;

  back_state_e state_q, state_d;
  logic [1:0]  pass_q, pass_d, idx_q, idx_d;
  logic [4:0]  cnt_q, cnt_d;
  job_t        job_q, job_d;

  logic signed [VEC_W-1:0] vec_q [3];
  logic signed [VEC_W-1:0] vec_d [3];
  logic [MAG_W-1:0]        mag_q [3];
  logic [MAG_W-1:0]        mag_d [3];
  logic signed [RES_W-1:0] res_q [3];
  logic signed [RES_W-1:0] res_d [3];
  logic signed [RES_W-1:0] ua_q [3];
  logic signed [RES_W-1:0] ua_d [3];

  logic [63:0] sum_q, sum_d, n_q, n_d, r_q, r_d, bit_q, bit_d;
  logic [59:0] prod_q, prod_d;
  logic [31:0] len_q, len_d, rem_q, rem_d, lo_q, lo_d, quo_q, quo_d;

  logic        out_valid_q, out_valid_d;
  logic signed [NORMAL_BITS-1:0] nx_q, ny_q, nz_q;
  logic [POS_W-1:0] orow_q, ocol_q;
  logic        ofe_q, load_out;

  logic [MAG_W-1:0] mmax;
  logic [29:0]      sq_in;
  logic [63:0]      r_sub, r_next, numer;
  logic             sq_ge, div_ge;
  logic [32:0]      div_t;
  logic [31:0]      quo_n, one, q_cl;

  always_comb begin
    mmax = mag_q[0];
    if (mag_q[1] > mmax) begin
      mmax = mag_q[1];
    end
    if (mag_q[2] > mmax) begin
      mmax = mag_q[2];
    end
  end

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    job_d   = job_q;
    vec_d   = vec_q;
    mag_d   = mag_q;
    res_d   = res_q;
    ua_d    = ua_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    n_d     = n_q;
    r_d     = r_q;
    bit_d   = bit_q;
    len_d   = len_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    job_ready_o = 1'b0;
    load_out    = 1'b0;

    case (cnt_q[1:0])
      2'd0:    sq_in = mag_q[0][29:0];
      2'd1:    sq_in = mag_q[1][29:0];
      default: sq_in = mag_q[2][29:0];
    endcase

    r_sub  = r_q + bit_q;
    sq_ge  = (n_q >= r_sub);
    r_next = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);

    one = (pass_q == 2'd2) ? (32'd1 << FRAC_OUT) : (32'd1 << FRAC_TRI);
    if (pass_q == 2'd2) begin
      numer = {34'd0, mag_q[idx_q][29:0]} << FRAC_OUT;
    end else begin
      numer = {34'd0, mag_q[idx_q][29:0]} << FRAC_TRI;
    end
    numer = numer + {33'd0, len_q[31:1]};

    div_t  = {rem_q, lo_q[31]};
    div_ge = (div_t >= {1'b0, len_q});
    quo_n  = {quo_q[30:0], div_ge};
    q_cl   = (quo_n > one) ? one : quo_n;

    unique case (state_q)
      BK_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          job_d    = job_i;
          vec_d[0] = -VEC_W'(job_i.drow);
          vec_d[1] = '0;
          vec_d[2] = VEC_W'({1'b0, job_i.step});
          pass_d   = 2'd0;
          state_d  = BK_ABS;
        end
      end
      BK_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag_d[i] = vec_q[i][VEC_W-1] ? MAG_W'(-vec_q[i]) : MAG_W'(vec_q[i]);
        end
        state_d = BK_SHIFT;
      end
      BK_SHIFT: begin
        // Bring the largest magnitude into [2^29, 2^30)
        if (mmax == '0) begin
          for (int i = 0; i < 3; i++) begin
            res_d[i] = '0;
          end
          state_d = BK_NEXT;
        end else if (mmax >= (MAG_W'(1) << 30)) begin
          for (int i = 0; i < 3; i++) begin
            mag_d[i] = mag_q[i] >> 1;
          end
        end else if (mmax < (MAG_W'(1) << 29)) begin
          for (int i = 0; i < 3; i++) begin
            mag_d[i] = mag_q[i] << 1;
          end
        end else begin
          cnt_d   = '0;
          sum_d   = '0;
          state_d = BK_SQ;
        end
      end
      BK_SQ: begin
        prod_d = 60'(sq_in) * 60'(sq_in);
        if (cnt_q != '0) begin
          sum_d = sum_q + {4'd0, prod_q};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          n_d     = sum_q + {4'd0, prod_q};
          r_d     = '0;
          bit_d   = 64'd1 << 62;
          cnt_d   = '0;
          state_d = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (sq_ge) begin
          n_d = n_q - r_sub;
        end
        r_d   = r_next;
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          len_d   = r_next[31:0];
          idx_d   = 2'd0;
          state_d = BK_DINIT;
        end
      end
      BK_DINIT: begin
        rem_d   = numer[63:32];
        lo_d    = numer[31:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        rem_d = div_ge ? 32'(div_t - {1'b0, len_q}) : div_t[31:0];
        lo_d  = lo_q << 1;
        quo_d = quo_n;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          res_d[idx_q] = vec_q[idx_q][VEC_W-1] ? -$signed(q_cl) : $signed(q_cl);
          if (idx_q == 2'd2) begin
            state_d = BK_NEXT;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = BK_DINIT;
          end
        end
      end
      BK_NEXT: begin
        if (pass_q == 2'd0) begin
          ua_d     = res_q;
          vec_d[0] = '0;
          vec_d[1] = -VEC_W'(job_q.dcol);
          vec_d[2] = VEC_W'({1'b0, job_q.step});
          pass_d   = 2'd1;
          state_d  = BK_ABS;
        end else if (pass_q == 2'd1) begin
          for (int i = 0; i < 3; i++) begin
            vec_d[i] = VEC_W'(ua_q[i]) + VEC_W'(res_q[i]);
          end
          pass_d  = 2'd2;
          state_d = BK_ABS;
        end else begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    job_q  <= job_d;
    vec_q  <= vec_d;
    mag_q  <= mag_d;
    res_q  <= res_d;
    ua_q   <= ua_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    n_q    <= n_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quo_q  <= quo_d;
    if (load_out) begin
      nx_q   <= res_q[0][NORMAL_BITS-1:0];
      ny_q   <= res_q[1][NORMAL_BITS-1:0];
      nz_q   <= res_q[2][NORMAL_BITS-1:0];
      orow_q <= job_q.row;
      ocol_q <= job_q.col;
      ofe_q  <= job_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign frame_end_o = ofe_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // Steep slopes with a small step can round the up component to zero
  a_up_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT) |-> (res_q[2] >= 0))
    else $error("up component of normal negative");

  a_len_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DINIT) |-> (len_q >= (32'd1 << 29)))
    else $error("vector length below normalized range");

endmodule

`default_nettype wire

// ===== sv/heightmap_normal_generator_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_normal_generator_core
// Height grid in raster order to unit surface normals with grid position.
//
// Input channel: one signed height sample per transaction (valid/ready),
// rows top to bottom, columns left to right. Output channel: one normal per
// transaction with its row, column and a frame_end flag on the last point.
// Configuration: write grid_rows (0), grid_cols (1), grid_step (2) through
// cfg_we_i/cfg_index_i/cfg_data_i while the block is idle.
// In the front end a sample passes through FR_RD1, FR_RD2 and FR_PUSH and
// waits in FR_PUSH while the queue is full. Each normal then passes through
// the shared normalization unit: three vector normalizations, each with a
// one-bit-per-cycle alignment shift, a sum of squares, a bit-serial square
// root and three divisions by the length. That unit sets the rate.
// A four-entry queue lets the front end take further samples while the
// unit works; when the receiver stalls, the result register holds, the
// unit stops and the queue and then the input back up. Reset returns to grid
// position zero and loads the register defaults; the line store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_normal_generator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [hmng_pkg::HEIGHT_BITS-1:0] height_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [hmng_pkg::NORMAL_BITS-1:0] normal_x_o,
  output logic signed [hmng_pkg::NORMAL_BITS-1:0] normal_y_o,
  output logic signed [hmng_pkg::NORMAL_BITS-1:0] normal_z_o,
  output logic [hmng_pkg::POS_W-1:0] out_row_o,
  output logic [hmng_pkg::POS_W-1:0] out_col_o,
  output logic             frame_end_o
);
  import hmng_pkg::*;

  logic [DIM_W-1:0]  rows_q, cols_q, rows_eff, cols_eff;
  logic [STEP_W-1:0] step_q, step_eff;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(256);
      cols_q <= DIM_W'(256);
      step_q <= STEP_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i[DIM_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[DIM_W-1:0];
        CFG_STEP: step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one; oversize saturates
  always_comb begin
    rows_eff = (rows_q == '0) ? DIM_W'(1) :
               (rows_q > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : rows_q;
    cols_eff = (cols_q == '0) ? DIM_W'(1) :
               (cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_q;
    step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
  end

  hmng_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .step_i      (step_eff),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .height_i    (height_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  hmng_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  hmng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire
